// ----- hw/rtl/mrpt_pkg.sv -----
// ----------------------------------------------------------------------------
// mrpt_pkg: shared constants and types of the Miller-Rabin tester
// Widths, screening primes and verdict codes used by the multiplier, the core and the bench.
// ----------------------------------------------------------------------------
package mrpt_pkg;

  localparam int NUMBER_WIDTH = 128;
  localparam int MAX_ROUNDS   = 64;
  localparam int CNT_W        = $clog2(NUMBER_WIDTH);
  localparam int HALF_W       = 64;
  localparam int ROUNDS_W     = 7;
  localparam int PASSED_W     = 6;
  localparam int REASON_W     = 3;
  localparam int NUM_PRIMES   = 12;
  localparam int PRIME_W      = 6;

  typedef logic [NUMBER_WIDTH-1:0] num_t;
  typedef logic [PRIME_W-1:0]      prime_t;

  localparam prime_t SCREEN_PRIMES [NUM_PRIMES] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
  };

  localparam logic [REASON_W-1:0] REASON_BELOW_TWO   = 3'd0;
  localparam logic [REASON_W-1:0] REASON_SMALL_PRIME = 3'd1;
  localparam logic [REASON_W-1:0] REASON_SMALL_DIV   = 3'd2;
  localparam logic [REASON_W-1:0] REASON_WITNESS     = 3'd3;
  localparam logic [REASON_W-1:0] REASON_PASSED      = 3'd4;

  localparam logic [ROUNDS_W-1:0] ROUNDS_RESET = 7'd12;

endpackage

// ----- hw/rtl/mrpt_if.sv -----
// ----------------------------------------------------------------------------
// mrpt_if: channel interfaces of the Miller-Rabin tester
// Candidate beats in, verdict beats out, and the round-count write channel.
// ----------------------------------------------------------------------------
interface mrpt_item_if;
  logic        valid;
  logic        ready;
  logic [63:0] candidate_low;
  logic [63:0] candidate_high;
  logic [63:0] random_low;
  logic [63:0] random_high;
  modport source (output valid, candidate_low, candidate_high, random_low, random_high,
                  input ready);
  modport sink   (input valid, candidate_low, candidate_high, random_low, random_high,
                  output ready);
endinterface

interface mrpt_result_if;
  logic       valid;
  logic       ready;
  logic       is_probable_prime;
  logic [2:0] verdict_reason;
  logic [6:0] rounds_done;
  modport source (output valid, is_probable_prime, verdict_reason, rounds_done,
                  input ready);
  modport sink   (input valid, is_probable_prime, verdict_reason, rounds_done,
                  output ready);
endinterface

interface mrpt_cfg_if;
  logic       valid;
  logic       ready;
  logic [6:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ----- hw/rtl/mrpt_modmul.sv -----
// ----------------------------------------------------------------------------
// mrpt_modmul: bit-serial modular multiplier
// Computes a*b mod n for a, b < n, one bit of b per cycle, MSB first.
// ----------------------------------------------------------------------------
module mrpt_modmul (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  mrpt_pkg::num_t a,
  input  mrpt_pkg::num_t b,
  input  mrpt_pkg::num_t n,
  output logic          done,
  output mrpt_pkg::num_t res
);
  import mrpt_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  num_t             a_r;
  num_t             b_sh;
  num_t             n_r;
  num_t             acc;
  num_t             acc_next;

  logic [NUMBER_WIDTH+1:0] t;
  logic [NUMBER_WIDTH+2:0] d1;
  logic [NUMBER_WIDTH+2:0] d2;

  // double, add the multiplicand, then fold back below n
  always_comb begin
    t  = {1'b0, acc, 1'b0} + {2'b00, (b_sh[NUMBER_WIDTH-1] ? a_r : '0)};
    d1 = {1'b0, t} - {3'b000, n_r};
    d2 = {1'b0, t} - {2'b00, n_r, 1'b0};
    if (!d2[NUMBER_WIDTH+2]) begin
      acc_next = d2[NUMBER_WIDTH-1:0];
    end else if (!d1[NUMBER_WIDTH+2]) begin
      acc_next = d1[NUMBER_WIDTH-1:0];
    end else begin
      acc_next = t[NUMBER_WIDTH-1:0];
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(NUMBER_WIDTH-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      b_sh <= b;
      n_r  <= n;
      acc  <= '0;
    end else if (busy) begin
      acc  <= acc_next;
      b_sh <= {b_sh[NUMBER_WIDTH-2:0], 1'b0};
    end
  end

  assign res = acc;

endmodule

// ----- hw/rtl/miller_rabin_prime_tester_core.sv -----
// ----------------------------------------------------------------------------
// miller_rabin_prime_tester_core: one Miller-Rabin round per candidate beat
// Steps per item: screen by small primes, split n-1, reduce the random word,
// then the modular multiplications (one per set bit of d plus one per bit of d,
// plus up to s-1 squarings), all on the bit-serial multiplier. One item at a time.
// Reset (synchronous, active high) sets the round count to 12 and clears the
// pass counter; no clearing pass is needed.
// ----------------------------------------------------------------------------
module miller_rabin_prime_tester_core (
  input  logic clk,
  input  logic rst,
  mrpt_item_if.sink     items,
  mrpt_result_if.source results,
  mrpt_cfg_if.sink      cfg
);
  import mrpt_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCREEN = 4'd1;
  localparam logic [3:0] ST_SPLIT  = 4'd2;
  localparam logic [3:0] ST_REDUCE = 4'd3;
  localparam logic [3:0] ST_POWCHK = 4'd4;
  localparam logic [3:0] ST_POWR   = 4'd5;
  localparam logic [3:0] ST_POWA   = 4'd6;
  localparam logic [3:0] ST_CHK1   = 4'd7;
  localparam logic [3:0] ST_SQR    = 4'd8;
  localparam logic [3:0] ST_EMIT   = 4'd9;

  logic [3:0]          state;
  logic [ROUNDS_W-1:0] rounds_cfg;
  logic [PASSED_W-1:0] passed;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    s_cnt;
  logic [CNT_W-1:0]    sq_cnt;
  num_t                n;
  num_t                rnd;
  num_t                sh;
  num_t                nm1;
  num_t                m3;
  num_t                rem;
  num_t                e;
  num_t                r;
  num_t                base;
  prime_t              lane [NUM_PRIMES];
  logic                v_prime;
  logic [REASON_W-1:0] v_reason;
  logic [ROUNDS_W-1:0] v_done;

  logic                mm_start;
  num_t                mm_a;
  num_t                mm_b;
  logic                mm_done;
  num_t                mm_res;

  logic [NUMBER_WIDTH:0]   shifted;
  logic [NUMBER_WIDTH+1:0] rdiff;
  logic [ROUNDS_W-1:0]     need;
  logic [ROUNDS_W-1:0]     done_cnt;
  logic                    any_eq;
  logic                    any_div;
  logic                    below_two;
  logic [CNT_W-1:0]        sq_next;

  assign items.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;

  // round count register
  always_ff @(posedge clk) begin
    if (rst) begin
      rounds_cfg <= ROUNDS_RESET;
    end else if (cfg.valid) begin
      rounds_cfg <= cfg.data;
    end
  end

  // clamp the round count to 1..MAX_ROUNDS
  always_comb begin
    need = rounds_cfg;
    if (rounds_cfg == '0) need = ROUNDS_W'(1);
    if (rounds_cfg > ROUNDS_W'(MAX_ROUNDS)) need = ROUNDS_W'(MAX_ROUNDS);
  end

  assign done_cnt = {1'b0, passed} + ROUNDS_W'(1);
  assign sq_next  = sq_cnt + 1'b1;

  // screen decisions from the settled remainder lanes
  always_comb begin
    below_two = (n[NUMBER_WIDTH-1:1] == '0);
    any_eq    = 1'b0;
    any_div   = 1'b0;
    for (int i = 0; i < NUM_PRIMES; i++) begin
      if (n[NUMBER_WIDTH-1:PRIME_W] == '0 && n[PRIME_W-1:0] == SCREEN_PRIMES[i]) any_eq = 1'b1;
      if (lane[i] == '0) any_div = 1'b1;
    end
  end

  // restoring reduction step of the random word by n-3
  always_comb begin
    shifted = {rem, sh[NUMBER_WIDTH-1]};
    rdiff   = {1'b0, shifted} - {2'b00, m3};
  end

  // multiplier operand selection
  always_comb begin
    mm_start = 1'b0;
    mm_a     = base;
    mm_b     = base;
    case (state)
      ST_POWCHK: begin
        if (e != '0) begin
          mm_start = 1'b1;
          if (e[0]) mm_a = r;
        end
      end
      ST_POWR: begin
        mm_start = mm_done;
      end
      ST_CHK1: begin
        mm_a = r;
        mm_b = r;
        mm_start = !(r == num_t'(1) || r == nm1) && (s_cnt > CNT_W'(1));
      end
      ST_SQR: begin
        mm_a = mm_res;
        mm_b = mm_res;
        mm_start = mm_done && (mm_res != nm1) && (sq_next < s_cnt);
      end
      default: begin
        mm_start = 1'b0;
      end
    endcase
  end

  mrpt_modmul u_modmul (
    .clk   (clk),
    .rst   (rst),
    .start (mm_start),
    .a     (mm_a),
    .b     (mm_b),
    .n     (n),
    .done  (mm_done),
    .res   (mm_res)
  );

  // control sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      passed        <= '0;
      cnt           <= '0;
      results.valid <= 1'b0;
    end else begin
      // drop a taken beat; the emit state reloads valid on its own
      if (results.valid && results.ready && state != ST_EMIT) results.valid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (items.valid) begin
            state <= ST_SCREEN;
            cnt   <= '0;
          end
        end
        ST_SCREEN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUMBER_WIDTH-1)) begin
            cnt <= '0;
            state <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (below_two || any_eq || any_div) begin
            state <= ST_EMIT;
          end else if (e[0]) begin
            state <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NUMBER_WIDTH-1)) begin
            state <= ST_POWCHK;
          end
        end
        ST_POWCHK: begin
          if (e == '0) state <= ST_CHK1;
          else if (e[0]) state <= ST_POWR;
          else state <= ST_POWA;
        end
        ST_POWR: begin
          if (mm_done) state <= ST_POWA;
        end
        ST_POWA: begin
          if (mm_done) state <= ST_POWCHK;
        end
        ST_CHK1: begin
          if (r == num_t'(1) || r == nm1) begin
            if (done_cnt >= need) state <= ST_EMIT;
            else begin
              passed <= done_cnt[PASSED_W-1:0];
              state  <= ST_IDLE;
            end
          end else if (s_cnt > CNT_W'(1)) begin
            state <= ST_SQR;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_SQR: begin
          if (mm_done) begin
            if (mm_res == nm1) begin
              if (done_cnt >= need) state <= ST_EMIT;
              else begin
                passed <= done_cnt[PASSED_W-1:0];
                state  <= ST_IDLE;
              end
            end else if (!(sq_next < s_cnt)) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (!results.valid || results.ready) begin
            results.valid <= 1'b1;
            passed        <= '0;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        n   <= num_t'({items.candidate_high, items.candidate_low});
        rnd <= num_t'({items.random_high, items.random_low});
        sh  <= num_t'({items.candidate_high, items.candidate_low});
        for (int i = 0; i < NUM_PRIMES; i++) lane[i] <= '0;
      end
      ST_SCREEN: begin
        // fold one bit of n into every remainder lane
        for (int i = 0; i < NUM_PRIMES; i++) begin
          if ({lane[i], sh[NUMBER_WIDTH-1]} >= {1'b0, SCREEN_PRIMES[i]}) begin
            lane[i] <= PRIME_W'({lane[i], sh[NUMBER_WIDTH-1]} - {1'b0, SCREEN_PRIMES[i]});
          end else begin
            lane[i] <= PRIME_W'({lane[i], sh[NUMBER_WIDTH-1]});
          end
        end
        if (cnt == CNT_W'(NUMBER_WIDTH-1)) begin
          nm1   <= n - num_t'(1);
          m3    <= n - num_t'(3);
          e     <= n - num_t'(1);
          s_cnt <= '0;
          sh    <= rnd;
          rem   <= '0;
        end else begin
          sh <= {sh[NUMBER_WIDTH-2:0], 1'b0};
        end
      end
      ST_SPLIT: begin
        // strip trailing zeros of n-1
        if (!e[0]) begin
          e     <= {1'b0, e[NUMBER_WIDTH-1:1]};
          s_cnt <= s_cnt + 1'b1;
        end
        if (below_two) begin
          v_prime <= 1'b0; v_reason <= REASON_BELOW_TWO;
        end else if (any_eq) begin
          v_prime <= 1'b1; v_reason <= REASON_SMALL_PRIME;
        end else begin
          v_prime <= 1'b0; v_reason <= REASON_SMALL_DIV;
        end
        v_done <= '0;
      end
      ST_REDUCE: begin
        if (!rdiff[NUMBER_WIDTH+1]) rem <= rdiff[NUMBER_WIDTH-1:0];
        else rem <= shifted[NUMBER_WIDTH-1:0];
        sh <= {sh[NUMBER_WIDTH-2:0], 1'b0};
        r  <= num_t'(1);
      end
      ST_POWR: begin
        if (mm_done) r <= mm_res;
      end
      ST_POWA: begin
        if (mm_done) begin
          base <= mm_res;
          e    <= {1'b0, e[NUMBER_WIDTH-1:1]};
        end
      end
      ST_CHK1: begin
        sq_cnt <= CNT_W'(1);
        v_done <= done_cnt;
        if (r == num_t'(1) || r == nm1) begin
          v_prime <= 1'b1; v_reason <= REASON_PASSED;
        end else begin
          v_prime <= 1'b0; v_reason <= REASON_WITNESS;
        end
      end
      ST_SQR: begin
        if (mm_done) begin
          sq_cnt <= sq_next;
          if (mm_res == nm1) begin
            v_prime <= 1'b1; v_reason <= REASON_PASSED;
          end
        end
      end
      ST_EMIT: begin
        if (!results.valid || results.ready) begin
          results.is_probable_prime <= v_prime;
          results.verdict_reason    <= v_reason;
          results.rounds_done       <= v_done;
        end
      end
      default: begin
        sh <= sh;
      end
    endcase
    // base is rem + 2 once the reduction finishes
    if (state == ST_REDUCE && cnt == CNT_W'(NUMBER_WIDTH-1)) begin
      if (!rdiff[NUMBER_WIDTH+1]) base <= rdiff[NUMBER_WIDTH-1:0] + num_t'(2);
      else base <= shifted[NUMBER_WIDTH-1:0] + num_t'(2);
    end
  end

  // checks on verdict consistency
  a_pass_is_prime: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.verdict_reason == REASON_PASSED |-> results.is_probable_prime)
    else $error("passed verdict without prime flag");

  a_screen_no_rounds: assert property (@(posedge clk) disable iff (rst)
    results.valid && (results.verdict_reason == REASON_BELOW_TWO ||
    results.verdict_reason == REASON_SMALL_PRIME ||
    results.verdict_reason == REASON_SMALL_DIV) |-> results.rounds_done == '0)
    else $error("screen verdict with rounds counted");

  a_witness_counted: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.verdict_reason == REASON_WITNESS |->
    !results.is_probable_prime && results.rounds_done != '0)
    else $error("witness verdict malformed");

endmodule

// ----- verif/miller_rabin_prime_tester_core_tb.sv -----
// ----------------------------------------------------------------------------
// miller_rabin_prime_tester_core_tb: self-checking bench of the prime tester
// Drives candidate beats and round-count writes, predicts each verdict with a
// behavioural Miller-Rabin model and checks every verdict beat in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module miller_rabin_prime_tester_core_tb;
  import mrpt_pkg::*;

  localparam int  BUSY_CYCLES = 40000;
  localparam longint CYCLE_LIMIT = 20000000;
  localparam logic [127:0] MERSENNE_127 = 128'd170141183460469231731687303715884105727;
  localparam logic [127:0] TOP_PRIME    = 128'd340282366920938463463374607431768211297;

  typedef struct packed {
    logic       prime;
    logic [2:0] reason;
    logic [6:0] done;
  } verdict_t;

  logic   clk;
  logic   rst;
  logic   quiet;
  longint cycles;
  int     errors;

  verdict_t   verdict_q[$];
  logic [6:0] rounds_cfg;
  logic [5:0] passed_cnt;

  logic [127:0] prime_pool [9];
  logic [127:0] comp_pool  [6];

  mrpt_item_if   item_ch ();
  mrpt_result_if res_ch ();
  mrpt_cfg_if    cfg_ch ();

  miller_rabin_prime_tester_core u_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (item_ch),
    .results (res_ch),
    .cfg     (cfg_ch)
  );

  // Clock, 2 ns period
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL miller_rabin_prime_tester_core");
      $finish;
    end
  end

  task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("mismatch %s: got %0d expected %0d", what, got, want);
  endtask

  function automatic logic [127:0] mul_mod(input logic [127:0] a, input logic [127:0] b,
                                           input logic [127:0] n);
    logic [255:0] prod;
    logic [255:0] rem;
    prod = {128'd0, a} * {128'd0, b};
    rem  = prod % {128'd0, n};
    return rem[127:0];
  endfunction

  function automatic logic [127:0] pow_mod(input logic [127:0] base, input logic [127:0] e,
                                           input logic [127:0] n);
    logic [127:0] acc;
    acc = 128'd1;
    for (int i = 0; i < 128; i++) begin
      if (e[i]) acc = mul_mod(acc, base, n);
      base = mul_mod(base, base, n);
    end
    return acc;
  endfunction

  // Work out the verdict of one round; return 1 when a beat is due
  function automatic bit predict_verdict(input logic [127:0] n, input logic [127:0] rnd,
                                         output verdict_t v);
    logic [127:0] nm1, d, base, x;
    logic [6:0]   need, done;
    int           s;
    bit           witness;
    v = '0;
    if (n < 2) begin
      v.reason = REASON_BELOW_TWO;
      passed_cnt = '0;
      return 1;
    end
    for (int i = 0; i < NUM_PRIMES; i++) begin
      if (n == 128'(SCREEN_PRIMES[i])) begin
        v.prime = 1'b1;
        v.reason = REASON_SMALL_PRIME;
        passed_cnt = '0;
        return 1;
      end
      if (n % 128'(SCREEN_PRIMES[i]) == 0) begin
        v.reason = REASON_SMALL_DIV;
        passed_cnt = '0;
        return 1;
      end
    end
    // split n-1 into d * 2^s
    nm1 = n - 1;
    d = nm1;
    s = 0;
    while (s < 127 && !d[0]) begin
      d = d >> 1;
      s++;
    end
    base = 128'd2 + rnd % (n - 3);
    x = pow_mod(base, d, n);
    witness = !(x == 1 || x == nm1);
    for (int i = 1; witness && i < s; i++) begin
      x = mul_mod(x, x, n);
      if (x == nm1) witness = 0;
    end
    done = {1'b0, passed_cnt} + 7'd1;
    if (witness) begin
      v.reason = REASON_WITNESS;
      v.done = done;
      passed_cnt = '0;
      return 1;
    end
    need = rounds_cfg;
    if (need < 1) need = 1;
    if (need > MAX_ROUNDS) need = MAX_ROUNDS;
    if (done >= need) begin
      v.prime = 1'b1;
      v.reason = REASON_PASSED;
      v.done = done;
      passed_cnt = '0;
      return 1;
    end
    passed_cnt = done[5:0];
    return 0;
  endfunction

  // Send one candidate beat; valid stays high after acceptance
  task automatic send_item(input logic [127:0] cand, input logic [127:0] rnd);
    int       gap;
    verdict_t v;
    gap = quiet ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
      @(negedge clk);
    end
    item_ch.valid          <= 1'b1;
    item_ch.candidate_low  <= cand[63:0];
    item_ch.candidate_high <= cand[127:64];
    item_ch.random_low     <= rnd[63:0];
    item_ch.random_high    <= rnd[127:64];
    do @(posedge clk); while (!item_ch.ready);
    if (predict_verdict(cand, rnd, v)) verdict_q = {verdict_q, v};
  endtask

  function automatic logic [127:0] rand128();
    return {$urandom, $urandom, $urandom, $urandom};
  endfunction

  // Hold off until every verdict is in and the core has finished its round
  task automatic wait_idle();
    @(negedge clk);
    item_ch.valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (BUSY_CYCLES) @(posedge clk);
  endtask

  task automatic write_rounds(input logic [6:0] value);
    wait_idle();
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    rounds_cfg = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Verdict side: random stall per beat, then compare with the oldest prediction
  initial begin
    int       stall;
    verdict_t want;
    res_ch.ready = 1'b0;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 4);
      @(negedge clk);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
        @(negedge clk);
      end
      res_ch.ready <= 1'b1;
      do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
      if (verdict_q.size() == 0) begin
        errors++;
        $display("verdict beat with nothing expected");
      end else begin
        want = verdict_q.pop_front();
        if (res_ch.is_probable_prime !== want.prime)
          report("is_probable_prime", 16'(res_ch.is_probable_prime), 16'(want.prime));
        if (res_ch.verdict_reason !== want.reason)
          report("verdict_reason", 16'(res_ch.verdict_reason), 16'(want.reason));
        if (res_ch.rounds_done !== want.done)
          report("rounds_done", 16'(res_ch.rounds_done), 16'(want.done));
      end
    end
  end

  // Below two, small primes, small divisors, and a composite past the screen
  task automatic test_screen();
    send_item(128'd0, rand128());
    send_item(128'd1, rand128());
    send_item(128'd2, rand128());
    send_item(128'd37, rand128());
    send_item(128'd1369, rand128());
    send_item({128{1'b1}}, {128{1'b1}});
    send_item(128'd1 << 64, '0);
    send_item(128'd3215031751, rand128());
  endtask

  // Reset round count: twelve passing rounds, then a witness and a big prime
  task automatic test_reset_rounds();
    repeat (12) send_item(128'd41, rand128());
    send_item(128'd1763, rand128());
    send_item(MERSENNE_127, {128{1'b1}});
  endtask

  // Out-of-range and extreme round counts
  task automatic test_round_limits();
    write_rounds(7'd0);
    send_item(TOP_PRIME, rand128());
    write_rounds(7'd127);
    send_item(128'd65537, rand128());
    send_item(128'd65537, rand128());
    send_item(128'd9, rand128());
    write_rounds(7'd64);
    send_item(128'd97, rand128());
    send_item(128'd0, rand128());
    write_rounds(7'd1);
    send_item(128'd1000000007, rand128());
  endtask

  // Mostly well-formed tests on primes and hard composites, the rest noise
  task automatic test_random(input int count);
    int pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        send_item(prime_pool[$urandom_range(0, 8)], rand128());
      else if (pick < 6)
        send_item(comp_pool[$urandom_range(0, 5)], rand128());
      else if (pick < 8)
        send_item(rand128(), rand128());
      else
        send_item(128'($urandom_range(0, 40)), rand128());
    end
  endtask

  initial begin
    prime_pool = '{128'd41, 128'd43, 128'd97, 128'd65537, 128'd1000000007,
                   128'd2305843009213693951, 128'd18446744073709551557,
                   MERSENNE_127, TOP_PRIME};
    comp_pool  = '{128'd1763, 128'd4171, 128'd65537 * 128'd97, 128'd3215031751,
                   128'd1000000007 * 128'd2305843009213693951,
                   128'd18446744073709551557 * 128'd43};
    cycles        = 0;
    errors        = 0;
    quiet         = 1'b0;
    rounds_cfg    = ROUNDS_RESET;
    passed_cnt    = '0;
    item_ch.valid = 1'b0;
    item_ch.candidate_low  = '0;
    item_ch.candidate_high = '0;
    item_ch.random_low     = '0;
    item_ch.random_high    = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_screen();
    test_reset_rounds();
    test_round_limits();
    quiet = 1'b1;
    write_rounds(7'($urandom_range(1, 4)));
    test_random(20);
    quiet = 1'b0;
    write_rounds(7'($urandom_range(1, 4)));
    test_random(25);
    write_rounds(7'($urandom_range(1, 3)));
    test_random(25);

    // Drain and let any stray beat show up
    wait_idle();
    if (errors == 0) begin
      $display("PASS miller_rabin_prime_tester_core");
    end else begin
      $display("FAIL miller_rabin_prime_tester_core");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/mrpt_pkg.sv
hw/rtl/mrpt_if.sv
hw/rtl/mrpt_modmul.sv
hw/rtl/miller_rabin_prime_tester_core.sv
verif/miller_rabin_prime_tester_core_tb.sv
